>>> src/rspr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rspr_pkg
// Shared codes, characters and helpers of the serial protocol packet receiver.
// ----------------------------------------------------------------------------
package rspr_pkg;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_GOOD     = 3'd1;
	localparam logic [2:0] EV_MISMATCH = 3'd2;
	localparam logic [2:0] EV_BADHEX   = 3'd3;
	localparam logic [2:0] EV_OVERFLOW = 3'd4;
	localparam logic [2:0] EV_READ     = 3'd5;

	localparam logic [7:0] CH_START = 8'h24; // '$'
	localparam logic [7:0] CH_HASH  = 8'h23; // '#'
	localparam logic [7:0] CH_ACK   = 8'h2B; // '+'
	localparam logic [7:0] CH_NAK   = 8'h2D; // '-'
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Framer verdict for one received byte.
	typedef struct packed {
		logic [2:0] ev;
		logic [7:0] ack;
		logic       wr_en;
	} frm_res_t;

	// Bit 4 flags a character that is not a hex digit; bits 3..0 hold its value.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = {1'b0, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = {1'b0, 4'(c - 8'h37)};
		end
		return v;
	endfunction

endpackage
`default_nettype wire

>>> src/rspr_frame.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rspr_frame
// Framing state machine: start hunt, payload sum, checksum digits, verdict.
// ----------------------------------------------------------------------------
module rspr_frame #(
	parameter int BUF_BYTES = 4096,
	parameter int CW        = $clog2(BUF_BYTES)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic [7:0]       rx_byte,
	output rspr_pkg::frm_res_t    res,
	output logic      [CW-1:0]    wr_addr,
	output logic      [CW-1:0]    len_next
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_DATA,
		PH_HEX1,
		PH_HEX2
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [CW-1:0]   count_q, count_d;
	logic [7:0]      sum_q, sum_d;
	logic [4:0]      hi_q, hi_d;
	logic [CW-1:0]   len_q, len_d;
	logic [4:0]      lo_val;
	logic            last_slot;

	assign lo_val    = rspr_pkg::hex_value(rx_byte);
	assign last_slot = (count_q == CW'(BUF_BYTES - 1));
	assign wr_addr   = count_q;
	assign len_next  = len_d;

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		sum_d     = sum_q;
		hi_d      = hi_q;
		len_d     = len_q;
		res.ev    = rspr_pkg::EV_NONE;
		res.ack   = rspr_pkg::CH_NUL;
		res.wr_en = 1'b0;
		if (en) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == rspr_pkg::CH_START) begin
						phase_d = PH_DATA;
						count_d = '0;
						sum_d   = '0;
					end
				end
				PH_DATA: begin
					if (rx_byte == rspr_pkg::CH_HASH) begin
						phase_d = PH_HEX1;
					end else begin
						res.wr_en = 1'b1;
						if (last_slot) begin
							// The buffer just filled: drop the packet without an ack.
							res.ev  = rspr_pkg::EV_OVERFLOW;
							phase_d = PH_HUNT;
							count_d = '0;
							sum_d   = '0;
						end else begin
							count_d = count_q + CW'(1);
							sum_d   = sum_q + rx_byte;
						end
					end
				end
				PH_HEX1: begin
					hi_d    = lo_val;
					phase_d = PH_HEX2;
				end
				PH_HEX2: begin
					if (hi_q[4] || lo_val[4]) begin
						res.ev  = rspr_pkg::EV_BADHEX;
						res.ack = rspr_pkg::CH_NAK;
					end else if ({hi_q[3:0], lo_val[3:0]} == sum_q) begin
						res.ev  = rspr_pkg::EV_GOOD;
						res.ack = rspr_pkg::CH_ACK;
						len_d   = count_q;
					end else begin
						res.ev  = rspr_pkg::EV_MISMATCH;
						res.ack = rspr_pkg::CH_NAK;
					end
					phase_d = PH_HUNT;
					count_d = '0;
					sum_d   = '0;
					hi_d    = '0;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			sum_q   <= '0;
			hi_q    <= '0;
			len_q   <= '0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			hi_q    <= hi_d;
			len_q   <= len_d;
		end
	end

endmodule
`default_nettype wire

>>> src/rsp_packet_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_packet_receiver
// Receive side of the debugger serial protocol with a payload buffer.
// ----------------------------------------------------------------------------
//  channel | handshake            | fields
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | action, rx_byte, read_index
//  out     | out_valid / out_ready| event_res, ack_byte, packet_length, read_data
//
// One item per cycle while out_ready is high; each result is registered after
// its item is accepted (input register, then result register with buffer read).
// The framer and the single-write, single-read payload buffer both act in the
// step from input register to result register. Reset clears the framer and
// the valid flags only; the buffer is not cleared. A stalled result holds
// both stages, and in_ready follows out_ready through the pipeline.
// ----------------------------------------------------------------------------
module rsp_packet_receiver #(
	parameter int BUF_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [11:0] read_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       event_res,
	output logic [7:0]       ack_byte,
	output logic [11:0]      packet_length,
	output logic [7:0]       read_data
);

	localparam int AW = $clog2(BUF_BYTES);
	localparam int IW = (AW > 12) ? AW : 12;

	logic               valid_s1, action_s1;
	logic [7:0]         byte_s1;
	logic [11:0]        idx_s1;
	logic               adv1;

	logic               valid_s2, rd_ok_s2;
	logic [2:0]         ev_s2;
	logic [7:0]         ack_s2;
	logic [11:0]        len_s2;
	logic [7:0]         rd_q;

	rspr_pkg::frm_res_t frm;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      len_next;
	logic [IW-1:0]      len_ext;
	logic [IW-1:0]      idx_ext;
	logic [AW-1:0]      rd_addr;
	logic               rd_in_range;

	logic [7:0]         mem [BUF_BYTES];

	assign adv1     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv1;

	rspr_frame #(
		.BUF_BYTES(BUF_BYTES),
		.CW       (AW)
	) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv1 && !action_s1),
		.rx_byte (byte_s1),
		.res     (frm),
		.wr_addr (wr_addr),
		.len_next(len_next)
	);

	assign len_ext     = IW'(len_next);
	assign idx_ext     = IW'(idx_s1);
	assign rd_addr     = idx_ext[AW-1:0];
	assign rd_in_range = ({20'd0, idx_s1} < 32'(BUF_BYTES));

	always_ff @(posedge clk) begin
		if (adv1 && !action_s1 && frm.wr_en) begin
			mem[wr_addr] <= byte_s1;
		end
		if (adv1 && action_s1) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			byte_s1   <= rx_byte;
			idx_s1    <= read_index;
		end
		if (adv1) begin
			len_s2 <= len_ext[11:0];
			if (action_s1) begin
				ev_s2    <= rspr_pkg::EV_READ;
				ack_s2   <= rspr_pkg::CH_NUL;
				rd_ok_s2 <= rd_in_range;
			end else begin
				ev_s2    <= frm.ev;
				ack_s2   <= frm.ack;
				rd_ok_s2 <= 1'b0;
			end
		end
	end

	assign out_valid     = valid_s2;
	assign event_res     = ev_s2;
	assign ack_byte      = ack_s2;
	assign packet_length = len_s2;
	assign read_data     = rd_ok_s2 ? rd_q : rspr_pkg::CH_NUL;

endmodule
`default_nettype wire
